FILE: rtl/core/edfs_pkg.sv
// Shared field widths and operation codes for the EDF tick scheduler.
`default_nettype none

package edfs_pkg;

  localparam int OP_W    = 1;
  localparam int INDEX_W = 4;
  localparam int LABEL_W = 8;
  localparam int FIELD_W = 16;
  localparam int ACT_W   = 5;

  localparam logic [OP_W-1:0] OP_TICK = 1'b0;
  localparam logic [OP_W-1:0] OP_LOAD = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/edfs_if.sv
// Channel interfaces: command in, schedule result out, configuration write.
`default_nettype none

interface edfs_cmd_if;
  import edfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [INDEX_W-1:0] task_index;
  logic [LABEL_W-1:0] task_label;
  logic [FIELD_W-1:0] burst;
  logic [FIELD_W-1:0] rel_deadline;
  logic [FIELD_W-1:0] period;

  modport source (
    output valid, operation, task_index, task_label, burst, rel_deadline, period,
    input  ready
  );
  modport sink (
    input  valid, operation, task_index, task_label, burst, rel_deadline, period,
    output ready
  );
endinterface

interface edfs_rsp_if;
  import edfs_pkg::*;
  logic               valid;
  logic               ready;
  logic               running;
  logic [INDEX_W-1:0] run_index;
  logic [LABEL_W-1:0] run_label;

  modport source (
    output valid, running, run_index, run_label,
    input  ready
  );
  modport sink (
    input  valid, running, run_index, run_label,
    output ready
  );
endinterface

interface edfs_cfg_if;
  import edfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/edfs_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module edfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/edf_tick_scheduler_core.sv
// Top level: periodic-task earliest-deadline-first dispatcher.
`default_nettype none

// Each cmd transaction yields exactly one rsp transaction. A load writes one
// task entry (if its index is below MAX_TASKS) and answers with running = 0;
// a new cmd is taken only once the previous result has been registered.
// A tick walks the active entries (n = min(active_tasks, MAX_TASKS)) through
// the state memory at one entry per cycle, releasing, comparing deadlines and
// advancing counters in a single read-modify-write sweep, then re-reads the
// chosen entry to take one unit off its work; an idle tick skips the re-read.
// The walk length is set by the single read port of the state memory.
// Work, deadline and phase counters come out of reset as zero through
// per-entry valid flags, so there is no clearing pass. A finished result waits
// in the rsp register while the next cmd is already being taken; that cmd then
// holds in its result cycle until the register frees up. The user must write
// configuration only while no command is outstanding; the block itself does
// not enforce it.
module edf_tick_scheduler_core #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  edfs_cmd_if.sink   cmd,
  edfs_cfg_if.sink   cfg,
  edfs_rsp_if.source rsp
);
  import edfs_pkg::*;

  localparam int AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int TB  = TIME_BITS;
  localparam int TDW = TIME_BITS + 2;
  localparam int DW  = 2 * TB + TDW;
  localparam int SW  = LABEL_W + 3 * TB;

  localparam logic signed [TDW-1:0] TTD_MIN = {1'b1, {(TDW-1){1'b0}}};

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DEC_RD = 3'd2;
  localparam logic [2:0] ST_DEC_WR = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]           state;
  logic [ACT_W-1:0]     active_tasks;
  logic [CW-1:0]        n_act;
  logic [CW-1:0]        rd_cnt;
  logic                 pend;
  logic [AW-1:0]        pend_idx;
  logic                 found;
  logic signed [TDW-1:0] best;
  logic [AW-1:0]        pick_idx;
  logic [LABEL_W-1:0]   pick_label;
  logic [MAX_TASKS-1:0] valid_bits;
  logic                 rd_vld;

  logic               rsp_valid;
  logic               rsp_running;
  logic [INDEX_W-1:0] rsp_index;
  logic [LABEL_W-1:0] rsp_label;

  logic          cmd_fire;
  logic          idx_ok;
  logic          rd_issue;
  logic [CW-1:0] n_clamp;
  logic [AW-1:0] rd_addr;

  logic          st_we;
  logic [SW-1:0] st_wdata;
  logic [SW-1:0] st_rdata;
  logic          dyn_we;
  logic [AW-1:0] dyn_waddr;
  logic [DW-1:0] dyn_wdata;
  logic [DW-1:0] dyn_rdata;
  logic [DW-1:0] dyn;

  logic [LABEL_W-1:0]    label;
  logic [TB-1:0]         burst_s;
  logic [TB-1:0]         deadline_s;
  logic [TB-1:0]         period_s;
  logic [TB-1:0]         work_cur;
  logic signed [TDW-1:0] ttd_cur;
  logic [TB-1:0]         phase_cur;
  logic                  release_hit;
  logic [TB-1:0]         work_rel;
  logic signed [TDW-1:0] ttd_rel;
  logic signed [TDW-1:0] ttd_adv;
  logic [TB-1:0]         phase_rel;
  logic                  cand;

  assign cmd.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid     = rsp_valid;
  assign rsp.running   = rsp_running;
  assign rsp.run_index = rsp_index;
  assign rsp.run_label = rsp_label;

  assign cmd_fire = cmd.valid && cmd.ready;
  assign idx_ok   = int'(cmd.task_index) < MAX_TASKS;
  assign n_clamp  = (int'(active_tasks) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(active_tasks);
  assign rd_issue = (state == ST_SCAN) && (rd_cnt < n_act);
  assign rd_addr  = (state == ST_DEC_RD) ? pick_idx : AW'(rd_cnt);

  // entry fields; counters of a never-written entry read as zero
  assign dyn        = rd_vld ? dyn_rdata : '0;
  assign label      = st_rdata[SW-1 -: LABEL_W];
  assign burst_s    = st_rdata[3*TB-1 -: TB];
  assign deadline_s = st_rdata[2*TB-1 -: TB];
  assign period_s   = st_rdata[TB-1:0];
  assign work_cur   = dyn[DW-1 -: TB];
  assign ttd_cur    = $signed(dyn[TB +: TDW]);
  assign phase_cur  = dyn[TB-1:0];

  assign release_hit = (phase_cur == period_s);
  assign work_rel    = release_hit ? burst_s : work_cur;
  assign ttd_rel     = release_hit ? $signed({2'b00, deadline_s}) : ttd_cur;
  assign phase_rel   = release_hit ? '0 : phase_cur;
  assign ttd_adv     = (ttd_rel != TTD_MIN) ? ttd_rel - TDW'(1) : ttd_rel;
  assign cand        = (work_rel != '0) && (!found || (ttd_rel < best));

  assign st_we    = cmd_fire && (cmd.operation == OP_LOAD) && idx_ok;
  assign st_wdata = {cmd.task_label, TB'(cmd.burst), TB'(cmd.rel_deadline), TB'(cmd.period)};

  always_comb begin
    dyn_we    = 1'b0;
    dyn_waddr = AW'(cmd.task_index);
    dyn_wdata = {TB'(cmd.burst), $signed({2'b00, TB'(cmd.rel_deadline)}), {TB{1'b0}}};
    case (state)
      ST_IDLE: begin
        dyn_we = st_we;
      end
      ST_SCAN: begin
        dyn_we    = pend;
        dyn_waddr = pend_idx;
        dyn_wdata = {work_rel, ttd_adv, phase_rel + TB'(1)};
      end
      ST_DEC_WR: begin
        dyn_we    = 1'b1;
        dyn_waddr = pick_idx;
        dyn_wdata = {work_cur - TB'(1), ttd_cur, phase_cur};
      end
      default: begin
        dyn_we = 1'b0;
      end
    endcase
  end

  edfs_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS), .AW(AW)) u_task_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (AW'(cmd.task_index)),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  edfs_ram #(.WIDTH(DW), .DEPTH(MAX_TASKS), .AW(AW)) u_state_ram (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (dyn_waddr),
    .wdata (dyn_wdata),
    .raddr (rd_addr),
    .rdata (dyn_rdata)
  );

  always_ff @(posedge clk) begin
    rd_vld <= valid_bits[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_tasks <= '0;
      valid_bits   <= '0;
      rsp_valid    <= 1'b0;
      rd_cnt       <= '0;
      pend         <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        active_tasks <= cfg.data;
      end
      if (dyn_we) begin
        valid_bits[dyn_waddr] <= 1'b1;
      end
      if ((state == ST_DONE) && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            found  <= 1'b0;
            rd_cnt <= '0;
            pend   <= 1'b0;
            n_act  <= n_clamp;
            state  <= (cmd.operation == OP_LOAD) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend     <= rd_issue;
          pend_idx <= AW'(rd_cnt);
          if (rd_issue) begin
            rd_cnt <= rd_cnt + CW'(1);
          end
          if (pend && cand) begin
            found      <= 1'b1;
            best       <= ttd_rel;
            pick_idx   <= pend_idx;
            pick_label <= label;
          end
          // sweep drained: last write-back has landed
          if (!rd_issue && !pend) begin
            state <= found ? ST_DEC_RD : ST_DONE;
          end
        end
        ST_DEC_RD: begin
          state <= ST_DEC_WR;
        end
        ST_DEC_WR: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_running <= found;
            rsp_index   <= found ? INDEX_W'(pick_idx) : '0;
            rsp_label   <= found ? pick_label : '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_load_to_done: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && (cmd.operation == OP_LOAD)) |=> (state == ST_DONE))
    else $error("load did not go straight to result");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (pend && rd_issue) |-> (AW'(rd_cnt) != pend_idx))
    else $error("scan read and write-back hit the same entry");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the result state");

  a_pick_written: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEC_WR) |-> rd_vld)
    else $error("picked entry has no valid counters");

endmodule

`default_nettype wire
